// ===== sv/efr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame receiver.
package efr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] ESC_XOR      = 8'h20;
    localparam logic [7:0] SUM_GOOD     = 8'hFF;
    localparam logic [7:0] START_RESET  = 8'd126;
    localparam logic [7:0] ESCAPE_RESET = 8'd125;

    // Configuration register indexes
    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ESCAPE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_ZERO_LEN  = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_BAD_SUM   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        EM_NONE  = 2'd0,
        EM_ERR   = 2'd1,
        EM_EMPTY = 2'd2,
        EM_PAY   = 2'd3
    } t_emit;

    typedef struct packed {
        logic    frame_open;
        logic    esc_set;
        logic    take;
        logic    len_load;
        logic    cmd_load;
        logic    pay_store;
        logic    rd_start;
        logic    rd_issue;
        logic    rd_next;
        t_emit   emit;
        t_status code;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_start;
        logic is_escape;
        logic byte_zero;
        logic remain_zero;
        logic idx_full;
        logic sum_good;
        logic len_m1_zero;
        logic drain_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/efr_datapath.sv =====
// Datapath: config registers, unescaping, checksum, payload buffer and output register.
module efr_datapath #(
    parameter int  MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF,
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int TD_W        = ((3 + 8 + CNT_W + 8) + 7) / 8 * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    input  logic [7:0]            s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TD_W-1:0]       m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  efr_pkg::t_ctl_cmd     i_cmd,
    output efr_pkg::t_dp_status   o_st
);

    logic [7:0]             r_start;
    logic [7:0]             r_escape;
    logic                   r_esc_pend;
    logic [7:0]             r_sum;
    logic [7:0]             r_len_m1;
    logic [7:0]             r_command;
    logic [CNT_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [7:0]             r_rd_data;
    logic [7:0]             mem [MAX_PAYLOAD];

    logic                   r_m_tvalid;
    efr_pkg::t_status       r_o_status;
    logic [7:0]             r_o_cmd;
    logic [CNT_W-1:0]       r_o_count;
    logic [7:0]             r_o_byte;
    logic                   r_o_valid;
    logic                   r_o_last;

    logic [7:0]             n_byte;
    logic [7:0]             n_sum;

    assign n_byte = r_esc_pend ? (s_tdata ^ efr_pkg::ESC_XOR) : s_tdata;
    assign n_sum  = r_sum + n_byte;

    always_comb begin
        o_st.is_start    = (s_tdata == r_start);
        o_st.is_escape   = (s_tdata == r_escape);
        o_st.byte_zero   = (n_byte == 8'd0);
        o_st.remain_zero = (9'(r_idx) == 9'(r_len_m1));
        o_st.idx_full    = (r_idx == CNT_W'(MAX_PAYLOAD));
        o_st.sum_good    = (n_sum == efr_pkg::SUM_GOOD);
        o_st.len_m1_zero = (r_len_m1 == 8'd0);
        o_st.drain_last  = ((9'(r_rd_idx) + 9'd1) == 9'(r_len_m1));
        o_st.out_free    = !r_m_tvalid || m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= efr_pkg::START_RESET;
            r_escape   <= efr_pkg::ESCAPE_RESET;
            r_esc_pend <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    efr_pkg::CFG_START:  r_start  <= i_cfg_wdata;
                    efr_pkg::CFG_ESCAPE: r_escape <= i_cfg_wdata;
                endcase
            end
            if (i_cmd.frame_open || i_cmd.take) begin
                r_esc_pend <= 1'b0;
            end else if (i_cmd.esc_set) begin
                r_esc_pend <= 1'b1;
            end
            if (i_cmd.emit != efr_pkg::EM_NONE) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_open) begin
            r_sum <= 8'd0;
            r_idx <= '0;
        end
        if (i_cmd.len_load) begin
            r_len_m1 <= n_byte - 8'd1;
        end
        if (i_cmd.cmd_load) begin
            r_command <= n_byte;
            r_sum     <= n_sum;
        end
        if (i_cmd.pay_store) begin
            r_sum <= n_sum;
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
        unique case (i_cmd.emit)
            efr_pkg::EM_ERR: begin
                r_o_status <= i_cmd.code;
                r_o_cmd    <= 8'd0;
                r_o_count  <= '0;
                r_o_byte   <= 8'd0;
                r_o_valid  <= 1'b0;
                r_o_last   <= 1'b1;
            end
            efr_pkg::EM_EMPTY: begin
                r_o_status <= efr_pkg::ST_OK;
                r_o_cmd    <= r_command;
                r_o_count  <= '0;
                r_o_byte   <= 8'd0;
                r_o_valid  <= 1'b0;
                r_o_last   <= 1'b1;
            end
            efr_pkg::EM_PAY: begin
                r_o_status <= efr_pkg::ST_OK;
                r_o_cmd    <= r_command;
                r_o_count  <= CNT_W'(r_len_m1);
                r_o_byte   <= r_rd_data;
                r_o_valid  <= 1'b1;
                r_o_last   <= o_st.drain_last;
            end
            default: begin
            end
        endcase
    end

    // Payload buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_store) begin
            mem[r_idx[IDX_W-1:0]] <= n_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = TD_W'({r_o_byte, r_o_count, r_o_cmd, r_o_status});
    assign m_tuser  = r_o_valid;
    assign m_tlast  = r_o_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && !m_tready) |-> (i_cmd.emit == efr_pkg::EM_NONE))
        else $error("output register loaded while a transfer is pending");

    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pay_store |-> (r_idx < CNT_W'(MAX_PAYLOAD)))
        else $error("payload write beyond buffer");

    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_o_valid) |-> (r_o_count != '0 && r_o_status == efr_pkg::ST_OK))
        else $error("payload result with zero count or error status");

endmodule

// ===== sv/efr_ctrl.sv =====
// Controller: frame parsing state machine and buffer drain sequencing.
module efr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  efr_pkg::t_dp_status   i_st,
    output efr_pkg::t_ctl_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_LEN,
        S_CMD,
        S_BODY,
        S_READ,
        S_SEND
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    assign s_tready = (r_state == S_WAIT || r_state == S_LEN || r_state == S_CMD ||
                       r_state == S_BODY) && i_st.out_free;
    assign w_fire   = s_tvalid && s_tready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.emit = efr_pkg::EM_NONE;
        o_cmd.code = efr_pkg::ST_OK;
        unique case (r_state)
            S_WAIT: begin
                if (w_fire && i_st.is_start) begin
                    o_cmd.frame_open = 1'b1;
                    n_state          = S_LEN;
                end
            end
            S_LEN, S_CMD, S_BODY: begin
                if (w_fire) begin
                    priority if (i_st.is_start) begin
                        o_cmd.emit = efr_pkg::EM_ERR;
                        o_cmd.code = efr_pkg::ST_BAD_START;
                        n_state    = S_WAIT;
                    end else if (i_st.is_escape) begin
                        o_cmd.esc_set = 1'b1;
                    end else begin
                        o_cmd.take = 1'b1;
                        unique case (r_state)
                            S_LEN: begin
                                if (i_st.byte_zero) begin
                                    o_cmd.emit = efr_pkg::EM_ERR;
                                    o_cmd.code = efr_pkg::ST_ZERO_LEN;
                                    n_state    = S_WAIT;
                                end else begin
                                    o_cmd.len_load = 1'b1;
                                    n_state        = S_CMD;
                                end
                            end
                            S_CMD: begin
                                o_cmd.cmd_load = 1'b1;
                                n_state        = S_BODY;
                            end
                            default: begin
                                // checksum byte when every payload byte is in
                                priority if (i_st.remain_zero) begin
                                    priority if (!i_st.sum_good) begin
                                        o_cmd.emit = efr_pkg::EM_ERR;
                                        o_cmd.code = efr_pkg::ST_BAD_SUM;
                                        n_state    = S_WAIT;
                                    end else if (i_st.len_m1_zero) begin
                                        o_cmd.emit = efr_pkg::EM_EMPTY;
                                        n_state    = S_WAIT;
                                    end else begin
                                        o_cmd.rd_start = 1'b1;
                                        n_state        = S_READ;
                                    end
                                end else if (i_st.idx_full) begin
                                    o_cmd.emit = efr_pkg::EM_ERR;
                                    o_cmd.code = efr_pkg::ST_TOO_LONG;
                                    n_state    = S_WAIT;
                                end else begin
                                    o_cmd.pay_store = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_SEND;
            end
            S_SEND: begin
                if (i_st.out_free) begin
                    o_cmd.emit    = efr_pkg::EM_PAY;
                    o_cmd.rd_next = 1'b1;
                    n_state       = i_st.drain_last ? S_WAIT : S_READ;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit != efr_pkg::EM_NONE) |-> i_st.out_free)
        else $error("result issued while output register is blocked");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit == efr_pkg::EM_PAY && i_st.drain_last) |=> (r_state == S_WAIT))
        else $error("drain did not end after last payload byte");

endmodule

// ===== sv/escaped_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver with checksum.
//
//  Channel  Dir  Signals                              Contents (low bit first)
//  s_*      in   s_tvalid/s_tready/s_tdata[7:0]       rx_byte
//  m_*      out  m_tvalid/m_tready/m_tdata/tuser/tlast status, frame_command,
//                                                     payload_count, payload_byte
//  cfg      in   i_cfg_we/i_cfg_addr/i_cfg_wdata      0 start_byte, 1 escape_byte
//
// One received byte is taken per cycle while a frame is parsed and the output is free.
// A good frame with N payload bytes drains its buffer one result at a time
// (registered buffer read, then output load); input is held off during the drain.
// Input stalls whenever the output register holds a result that is not taken.
// Reset is synchronous; no clearing pass, the buffer is only read where written.
module escaped_frame_receiver #(
    parameter int  MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF,
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1),
    localparam int TD_W        = ((3 + 8 + CNT_W + 8) + 7) / 8 * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // rx_byte
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [TD_W-1:0] m_tdata,   // status, frame_command, payload_count, payload_byte
    output logic            m_tuser,   // byte_valid
    output logic            m_tlast    // last_result
);

    efr_pkg::t_ctl_cmd   w_cmd;
    efr_pkg::t_dp_status w_st;

    efr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_st     (w_st),
        .o_cmd    (w_cmd)
    );

    efr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cmd       (w_cmd),
        .o_st        (w_st)
    );

endmodule
